// ----- rtl/sacl_pkg.sv -----
// Shared types and codes for the set-associative tag store.
// Used by the front end, back end and top level; depends on nothing.
package sacl_pkg;

  // Width of the way field of a result.
  localparam int unsigned RSP_WAY_W = 3;

  // Operation codes of a request.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_EVICT = 1'b1;

  // Replacement mode register codes.
  localparam logic MODE_LRU = 1'b0;
  localparam logic MODE_OPT = 1'b1;

  // One request transaction.
  typedef struct packed {
    logic               operation;
    logic [31:0]        address;
    logic signed [31:0] priority_req;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic                 hit;
    logic [RSP_WAY_W-1:0] way;
    logic                 replaced_valid;
  } rsp_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK,
    BK_SCAN,
    BK_FILL
  } back_state_e;

endpackage

// ----- rtl/set_assoc_cache_lru_opt.sv -----
// Top level of the set-associative tag store with LRU or supplied-priority replacement.
// Uses sacl_pkg; instantiates sacl_front, sacl_queue and sacl_back.

// After reset the block sweeps its tag RAM one set per cycle and holds busy high until the
// sweep is done. A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with done_o, and the receiver cannot stall it.
// The front end decodes a request with a mask of the block number when SETS is a power of
// two and otherwise by a reciprocal multiplication, then the remainder, and a two-entry
// queue lets it take further requests while the back end works. The back end handles a
// request through one read-modify-write of the set row in the tag RAM, in states IDLE and
// LOOK; a read miss on a full set adds a victim scan in SCAN, which visits one way per
// cycle, and then FILL; the result is registered and shows in the cycle after LOOK or FILL.
// The back end takes its next request only in IDLE. The replacement mode is written through
// the cfg port, which is always ready, and should change only while no request is in flight.
module set_assoc_cache_lru_opt #(
  parameter int unsigned WAYS      = 8,
  parameter int unsigned SETS      = 2048,
  parameter int unsigned BLOCK_LOG = 4,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sacl_pkg::req_t req_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i,
  output logic           done_o,
  output sacl_pkg::rsp_t rsp_o
);

  localparam int unsigned ABITS   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int unsigned SET_LOG = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int unsigned SET_W   = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int unsigned TSHIFT  = BLOCK_LOG + SET_LOG;
  localparam int unsigned TAG_W   = (ABITS > TSHIFT + 1) ? (ABITS - TSHIFT) : 1;
  localparam int unsigned QW      = 1 + SET_W + TAG_W + 32;

  logic          mode_q;
  logic          front_ready;
  logic          take;
  logic          push;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          clearing;

  // Requests wait while the tag RAM is being cleared or the front end is full.
  assign busy        = clearing || !front_ready;
  assign take        = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Replacement mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sacl_pkg::MODE_LRU;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  sacl_front #(
    .SETS      (SETS),
    .BLOCK_LOG (BLOCK_LOG),
    .ADDR_BITS (ADDR_BITS),
    .SET_W     (SET_W),
    .TAG_W     (TAG_W),
    .QW        (QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .req_i       (req_i),
    .ready_o     (front_ready),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (q_full)
  );

  sacl_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  sacl_back #(
    .WAYS  (WAYS),
    .SETS  (SETS),
    .SET_W (SET_W),
    .TAG_W (TAG_W),
    .QW    (QW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .pop_valid_i (q_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .clearing_o  (clearing),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- rtl/sacl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/sacl_front.sv -----
// Front end: accepts a request, cuts the address and splits it into set and tag.
// Uses sacl_pkg::req_t; feeds the request queue.
module sacl_front #(
  parameter int unsigned SETS      = 2048,
  parameter int unsigned BLOCK_LOG = 4,
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned SET_W     = 11,
  parameter int unsigned TAG_W     = 17,
  parameter int unsigned QW        = 1 + SET_W + TAG_W + 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  sacl_pkg::req_t  req_i,
  output logic            ready_o,
  output logic            push_o,
  output logic [QW-1:0]   push_data_o,
  input  logic            full_i
);

  localparam int unsigned ABITS     = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int unsigned SET_LOG   = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int unsigned TSHIFT    = BLOCK_LOG + SET_LOG;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ABITS) - 64'd1);
  localparam bit          SETS_POW2 = ((SETS & (SETS - 1)) == 0);

  logic               pend_q;
  logic               op_q;
  logic [TAG_W-1:0]   tag_q;
  logic [31:0]        prio_q;
  logic [31:0]        addr_cut;
  logic [31:0]        blk;
  logic [31:0]        tag_full;
  logic [SET_W-1:0]   set_val;
  logic               done;

  // Address cut to the address width, then block number and tag.
  assign addr_cut = req_i.address & ADDR_MASK;
  assign blk      = addr_cut >> BLOCK_LOG;
  assign tag_full = addr_cut >> TSHIFT;

  if (SETS_POW2) begin : g_pow2
    logic [SET_W-1:0] set_q;

    // Set count is a power of two: the set index is a mask of the block number.
    always_ff @(posedge clk_i) begin
      if (take_i) begin
        set_q <= SET_W'(blk) & SET_W'(SETS - 1);
      end
    end

    assign set_val = set_q;
    assign done    = pend_q;
  end else begin : g_div
    // The reciprocal is exact for every 32-bit block number with this shift.
    localparam int unsigned RSH   = 32 + SET_LOG;
    localparam logic [63:0] RECIP = ((64'd1 << RSH) + 64'(SETS) - 64'd1) / 64'(SETS);

    logic [31:0] blk_q;
    logic [31:0] quo_q;
    logic        step_q;
    logic [65:0] prod;
    logic [31:0] rem_val;

    // Quotient by reciprocal multiplication, registered; the remainder is formed combinationally from it.
    assign prod    = 66'(blk_q) * 66'(RECIP[33:0]);
    assign rem_val = blk_q - (quo_q * 32'(SETS));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= 1'b0;
      end else if (take_i) begin
        step_q <= 1'b0;
      end else if (pend_q) begin
        step_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (take_i) begin
        blk_q <= blk;
      end
      quo_q <= 32'(prod >> RSH);
    end

    assign set_val = rem_val[SET_W-1:0];
    assign done    = pend_q && step_q;
  end

  // Hand the decoded request to the queue as soon as there is room.
  assign push_o      = done && !full_i;
  assign ready_o     = !pend_q || push_o;
  assign push_data_o = {op_q, set_val, tag_q, prio_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (take_i) begin
      pend_q <= 1'b1;
    end else if (push_o) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      op_q   <= req_i.operation;
      tag_q  <= tag_full[TAG_W-1:0];
      prio_q <= req_i.priority_req;
    end
  end

endmodule

// ----- rtl/sacl_queue.sv -----
// Two-entry queue of decoded requests between the front and back ends.
// No package needed.
module sacl_queue #(
  parameter int unsigned WIDTH = 62
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/sacl_back.sv -----
// Back end: reads a set row, looks up the tag, picks a victim and writes the row back.
// Uses sacl_pkg (codes, rsp_t, back_state_e) and instantiates sacl_ram.
module sacl_back #(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned SETS  = 2048,
  parameter int unsigned SET_W = 11,
  parameter int unsigned TAG_W = 17,
  parameter int unsigned QW    = 1 + SET_W + TAG_W + 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mode_i,
  input  logic           pop_valid_i,
  output logic           pop_o,
  input  logic [QW-1:0]  pop_data_i,
  output logic           clearing_o,
  output logic           done_o,
  output sacl_pkg::rsp_t rsp_o
);

  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENTRY_W = 1 + TAG_W + 32;
  localparam int unsigned ROW_W   = WAYS * ENTRY_W;

  sacl_pkg::back_state_e state_q, state_d;

  logic [SET_W-1:0] clr_q, clr_d;
  logic [31:0]      counter_q, counter_d;
  logic             done_q, done_d;
  sacl_pkg::rsp_t   rsp_q, rsp_d;

  logic             op_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [31:0]      prio_q;
  logic [WAY_W-1:0] vic_q, vic_d;
  logic [WAY_W-1:0] scan_q, scan_d;
  logic [31:0]      min_q, min_d;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  logic             row_valid [WAYS];
  logic [TAG_W-1:0] row_tag   [WAYS];
  logic [31:0]      row_stamp [WAYS];
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             any_inv;
  logic [WAY_W-1:0] inv_way;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (pop_data_i[32+TAG_W +: SET_W]),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = (state_q == sacl_pkg::BK_CLEAR);
  assign pop_o      = (state_q == sacl_pkg::BK_IDLE) && pop_valid_i;
  assign done_o     = done_q;
  assign rsp_o      = rsp_q;

  // Split the row read from the RAM into its ways, then match tags.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      row_valid[i] = ram_rdata[i*ENTRY_W + ENTRY_W - 1];
      row_tag[i]   = ram_rdata[i*ENTRY_W + 32 +: TAG_W];
      row_stamp[i] = ram_rdata[i*ENTRY_W +: 32];
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (row_valid[i] && (row_tag[i] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!row_valid[i]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(i);
      end
    end
  end

  // Sequencer: clearing pass, lookup, victim scan and row write-back.
  always_comb begin
    logic             wr_en;
    logic [WAY_W-1:0] wr_way;
    logic             wr_valid;
    logic [31:0]      wr_stamp;
    logic             cnt_stamp;
    logic [WAY_W+2:0] way_ext;

    state_d   = state_q;
    clr_d     = clr_q;
    counter_d = counter_q;
    vic_d     = vic_q;
    scan_d    = scan_q;
    min_d     = min_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    wr_en     = 1'b0;
    wr_way    = hit_way;
    wr_valid  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = ram_rdata;
    way_ext   = '0;

    // Counter stamps for LRU reads and for every evict.
    cnt_stamp = (op_q == sacl_pkg::OP_EVICT) || (mode_i == sacl_pkg::MODE_LRU);
    wr_stamp  = cnt_stamp ? (counter_q + 32'd1) : prio_q;

    unique case (state_q)
      sacl_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + SET_W'(1);
        if (clr_q == SET_W'(SETS - 1)) begin
          state_d = sacl_pkg::BK_IDLE;
        end
      end
      sacl_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = sacl_pkg::BK_LOOK;
        end
      end
      sacl_pkg::BK_LOOK: begin
        state_d = sacl_pkg::BK_IDLE;
        done_d  = 1'b1;
        rsp_d.replaced_valid = 1'b0;
        if (op_q == sacl_pkg::OP_EVICT) begin
          // Evict: bump the stamp and drop the line on a hit.
          wr_en    = hit;
          wr_way   = hit_way;
          wr_valid = 1'b0;
          way_ext  = {3'b000, hit_way};
          rsp_d.hit = hit;
          rsp_d.way = hit ? way_ext[2:0] : '0;
        end else if (hit) begin
          wr_en    = 1'b1;
          wr_way   = hit_way;
          way_ext  = {3'b000, hit_way};
          rsp_d.hit = 1'b1;
          rsp_d.way = way_ext[2:0];
        end else if (any_inv || (WAYS == 1)) begin
          // Fill the first free way; a single full way is its own victim.
          wr_en    = 1'b1;
          wr_way   = any_inv ? inv_way : '0;
          way_ext  = {3'b000, wr_way};
          rsp_d.hit = 1'b0;
          rsp_d.way = way_ext[2:0];
          rsp_d.replaced_valid = !any_inv;
        end else begin
          // Full set: look for the smallest stamp, one way per cycle.
          done_d  = 1'b0;
          vic_d   = '0;
          min_d   = row_stamp[0];
          scan_d  = WAY_W'(1);
          state_d = sacl_pkg::BK_SCAN;
        end
      end
      sacl_pkg::BK_SCAN: begin
        if ($signed(row_stamp[scan_q]) < $signed(min_q)) begin
          vic_d = scan_q;
          min_d = row_stamp[scan_q];
        end
        scan_d = scan_q + WAY_W'(1);
        if (scan_q == WAY_W'(WAYS - 1)) begin
          state_d = sacl_pkg::BK_FILL;
        end
      end
      sacl_pkg::BK_FILL: begin
        wr_en   = 1'b1;
        wr_way  = vic_q;
        way_ext = {3'b000, vic_q};
        done_d  = 1'b1;
        rsp_d.hit            = 1'b0;
        rsp_d.way            = way_ext[2:0];
        rsp_d.replaced_valid = 1'b1;
        state_d = sacl_pkg::BK_IDLE;
      end
      default: begin
        state_d = sacl_pkg::BK_IDLE;
      end
    endcase

    // Merge the updated way into the row and write it back.
    if (wr_en) begin
      ram_we = 1'b1;
      for (int i = 0; i < WAYS; i++) begin
        if (wr_way == WAY_W'(i)) begin
          ram_wdata[i*ENTRY_W +: ENTRY_W] = {wr_valid, tag_q, wr_stamp};
        end
      end
      if (cnt_stamp) begin
        counter_d = counter_q + 32'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sacl_pkg::BK_CLEAR;
      clr_q     <= '0;
      counter_q <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      counter_q <= counter_d;
      done_q    <= done_d;
      rsp_q     <= rsp_d;
    end
  end

  // Request being worked on and victim search registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q   <= pop_data_i[QW-1];
      set_q  <= pop_data_i[32+TAG_W +: SET_W];
      tag_q  <= pop_data_i[32 +: TAG_W];
      prio_q <= pop_data_i[31:0];
    end
    vic_q  <= vic_d;
    scan_q <= scan_d;
    min_q  <= min_d;
  end

endmodule
